// ===== hw/rtl/md4_stream_hasher_top_assert.svh =====
// Assertion macros for the MD4 stream hasher.
`ifndef MD4_STREAM_HASHER_TOP_ASSERT_SVH
`define MD4_STREAM_HASHER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MD4_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MD4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/md4_pkg.sv =====
// ----------------------------------------------------------------------------
// md4_pkg
// Types and constants shared by the MD4 stream hasher controller and datapath.
// ----------------------------------------------------------------------------
package md4_pkg;

  localparam logic [31:0] IvWord0 = 32'h67452301;
  localparam logic [31:0] IvWord1 = 32'hEFCDAB89;
  localparam logic [31:0] IvWord2 = 32'h98BADCFE;
  localparam logic [31:0] IvWord3 = 32'h10325476;
  localparam logic [31:0] Round2Add = 32'h5A827999;
  localparam logic [31:0] Round3Add = 32'h6ED9EBA1;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam logic [5:0]  LenPos = 6'd56;
  localparam logic [5:0]  LastStep = 6'd47;

  typedef enum logic [2:0] {
    StIdle,
    StComp,
    StPad,
    StFinal
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic       put_en;     // write one byte into the buffer
    logic [7:0] put_byte;
    logic       cnt_inc;    // advance bit count
    logic       pos_inc;    // advance pad position only
    logic       len_wr;     // write bit count to words 14 and 15
    logic       comp_start; // load working words from chaining value
    logic       comp_step;  // run one round step
    logic       comp_end;   // fold working words into chaining value
    logic       out_load;   // capture digest
    logic       msg_clear;  // back to initial vector, zero count
  } md4_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [5:0] pos;
    logic [5:0] step;
  } md4_sts_t;

  function automatic logic [3:0] word_index(input logic [5:0] j);
    logic [3:0] k;
    k = j[3:0];
    case (j[5:4])
      2'd0:    word_index = k;
      2'd1:    word_index = {k[1:0], k[3:2]};
      default: word_index = {k[0], k[1], k[2], k[3]};
    endcase
  endfunction

  function automatic logic [4:0] shift_amt(input logic [5:0] j);
    case (j[5:4])
      2'd0: begin
        case (j[1:0])
          2'd0: shift_amt = 5'd3;
          2'd1: shift_amt = 5'd7;
          2'd2: shift_amt = 5'd11;
          default: shift_amt = 5'd19;
        endcase
      end
      2'd1: begin
        case (j[1:0])
          2'd0: shift_amt = 5'd3;
          2'd1: shift_amt = 5'd5;
          2'd2: shift_amt = 5'd9;
          default: shift_amt = 5'd13;
        endcase
      end
      default: begin
        case (j[1:0])
          2'd0: shift_amt = 5'd3;
          2'd1: shift_amt = 5'd9;
          2'd2: shift_amt = 5'd11;
          default: shift_amt = 5'd15;
        endcase
      end
    endcase
  endfunction

endpackage

// ===== hw/rtl/md4_ctrl.sv =====
// ----------------------------------------------------------------------------
// md4_ctrl
// Sequencer: byte intake, compression steps, padding and digest handoff.
// ----------------------------------------------------------------------------
module md4_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              byte_valid_i,
  input  logic              end_of_message_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  md4_pkg::md4_sts_t sts_i,
  output md4_pkg::md4_cmd_t cmd_o
);

  md4_pkg::state_e state_q, state_d;
  logic fin_q, fin_d;   // padding pending, until the length is placed
  logic mark_q, mark_d; // pad marker not yet written
  logic len_q, len_d;   // length already placed, next compression is the last
  logic outv_q, outv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= md4_pkg::StIdle;
      fin_q   <= 1'b0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
      outv_q  <= outv_d;
    end
  end

  assign out_valid_o = outv_q;

  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    mark_d     = mark_q;
    len_d      = len_q;
    outv_d     = outv_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    // drop the digest once its beat is taken
    if (outv_q && out_ready_i) outv_d = 1'b0;
    unique case (state_q)
      md4_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (byte_valid_i) begin
            cmd_o.put_en   = 1'b1;
            cmd_o.put_byte = data_byte_i;
            cmd_o.cnt_inc  = 1'b1;
          end
          fin_d  = end_of_message_i;
          mark_d = end_of_message_i;
          len_d  = 1'b0;
          if (byte_valid_i && sts_i.pos == 6'd63) begin
            cmd_o.comp_start = 1'b1;
            state_d = md4_pkg::StComp;
          end else if (end_of_message_i) begin
            state_d = md4_pkg::StPad;
          end
        end
      end
      md4_pkg::StComp: begin
        cmd_o.comp_step = 1'b1;
        if (sts_i.step == md4_pkg::LastStep) begin
          cmd_o.comp_end = 1'b1;
          if (len_q) state_d = md4_pkg::StFinal;
          else if (fin_q) state_d = md4_pkg::StPad;
          else state_d = md4_pkg::StIdle;
        end
      end
      md4_pkg::StPad: begin
        // marker on first pad beat, zeros after
        cmd_o.put_en   = 1'b1;
        cmd_o.put_byte = mark_q ? md4_pkg::PadMark : 8'h00;
        cmd_o.pos_inc  = 1'b1;
        mark_d = 1'b0;
        if (sts_i.pos == 6'd63) begin
          cmd_o.comp_start = 1'b1;
          state_d = md4_pkg::StComp;
        end else if (sts_i.pos == md4_pkg::LenPos - 6'd1) begin
          cmd_o.len_wr     = 1'b1;
          cmd_o.comp_start = 1'b1;
          fin_d   = 1'b0;
          len_d   = 1'b1;
          state_d = md4_pkg::StComp;
        end
      end
      md4_pkg::StFinal: begin
        // hold until the output register is free
        if (!outv_q || out_ready_i) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.msg_clear = 1'b1;
          outv_d  = 1'b1;
          len_d   = 1'b0;
          state_d = md4_pkg::StIdle;
        end
      end
      default: state_d = md4_pkg::StIdle;
    endcase
  end

  `include "md4_stream_hasher_top_assert.svh"

  `MD4_ASSERT_NEXT(a_out_hold, outv_q && !out_ready_i, outv_q, "digest dropped while stalled")
  `MD4_ASSERT_IMPL(a_no_take_busy, in_ready_o, state_q == md4_pkg::StIdle, "accept while busy")
  `MD4_ASSERT_IMPL(a_load_free, cmd_o.out_load, !outv_q || out_ready_i, "digest overwritten")
  `MD4_ASSERT_IMPL(a_step_end, state_q == md4_pkg::StComp && sts_i.step == md4_pkg::LastStep,
                   cmd_o.comp_end, "compression not folded")

endmodule

// ===== hw/rtl/md4_dpath.sv =====
// ----------------------------------------------------------------------------
// md4_dpath
// Block buffer, bit count, chaining value and one MD4 step per cycle.
// ----------------------------------------------------------------------------
module md4_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md4_pkg::md4_cmd_t cmd_i,
  output md4_pkg::md4_sts_t sts_o,
  output logic [63:0]       digest_low_o,
  output logic [63:0]       digest_high_o
);

  logic [31:0] buf_q [16];
  logic [31:0] cv_q [4];
  logic [31:0] ww_q [4];
  logic [63:0] cnt_q;
  logic [5:0]  pad_q;   // pad write position
  logic [5:0]  step_q;
  logic [63:0] dlo_q, dhi_q;

  logic [5:0]  pos;
  logic [31:0] b, c, d, a, f, sum, rot, w;
  logic [1:0]  ia;
  logic [4:0]  s;

  // pad beats track their own position; byte beats use the count
  assign pos = cmd_i.pos_inc ? pad_q : cnt_q[8:3];
  assign sts_o.pos  = pos;
  assign sts_o.step = step_q;

  assign ia = 2'd0 - step_q[1:0];
  assign a  = ww_q[ia];
  assign b  = ww_q[2'd1 - step_q[1:0]];
  assign c  = ww_q[2'd2 - step_q[1:0]];
  assign d  = ww_q[2'd3 - step_q[1:0]];
  assign w  = buf_q[md4_pkg::word_index(step_q)];
  assign s  = md4_pkg::shift_amt(step_q);

  always_comb begin
    case (step_q[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = ((b & c) | (b & d) | (c & d)) + md4_pkg::Round2Add;
      default: f = (b ^ c ^ d) + md4_pkg::Round3Add;
    endcase
    sum = a + f + w;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put_en) buf_q[pos[5:2]][pos[1:0]*8 +: 8] <= cmd_i.put_byte;
    if (cmd_i.len_wr) begin
      buf_q[14] <= cnt_q[31:0];
      buf_q[15] <= cnt_q[63:32];
    end
    if (cmd_i.comp_start) begin
      for (int i = 0; i < 4; i++) ww_q[i] <= cv_q[i];
    end else if (cmd_i.comp_step) begin
      ww_q[ia] <= rot;
    end
    if (cmd_i.out_load) begin
      dlo_q <= {cv_q[1], cv_q[0]};
      dhi_q <= {cv_q[3], cv_q[2]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= md4_pkg::IvWord0;
      cv_q[1] <= md4_pkg::IvWord1;
      cv_q[2] <= md4_pkg::IvWord2;
      cv_q[3] <= md4_pkg::IvWord3;
      cnt_q   <= '0;
      pad_q   <= '0;
      step_q  <= '0;
    end else begin
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + 64'd8;
      if (cmd_i.pos_inc) pad_q <= pad_q + 6'd1;
      else if (!cmd_i.comp_step) pad_q <= cnt_q[8:3] + (cmd_i.cnt_inc ? 6'd1 : 6'd0);
      if (cmd_i.comp_step) begin
        step_q <= (step_q == md4_pkg::LastStep) ? 6'd0 : step_q + 6'd1;
      end
      if (cmd_i.comp_end) begin
        cv_q[0] <= cv_q[0] + ((ia == 2'd0) ? rot : ww_q[0]);
        cv_q[1] <= cv_q[1] + ((ia == 2'd1) ? rot : ww_q[1]);
        cv_q[2] <= cv_q[2] + ((ia == 2'd2) ? rot : ww_q[2]);
        cv_q[3] <= cv_q[3] + ((ia == 2'd3) ? rot : ww_q[3]);
      end
      if (cmd_i.msg_clear) begin
        cv_q[0] <= md4_pkg::IvWord0;
        cv_q[1] <= md4_pkg::IvWord1;
        cv_q[2] <= md4_pkg::IvWord2;
        cv_q[3] <= md4_pkg::IvWord3;
        cnt_q   <= '0;
      end
    end
  end

  assign digest_low_o  = dlo_q;
  assign digest_high_o = dhi_q;

endmodule

// ===== hw/rtl/md4_stream_hasher_top.sv =====
// End of message: padding writes one byte a cycle through byte 55 (plus a full block on
// overflow), each compression runs 48 steps of one shared round unit, and the digest is
// captured in StFinal once the output register is free. A 64-byte block is 64 byte beats,
// then 48 round steps with no input taken; other bytes leave the hasher idle. A waiting
// digest stalls the next digest handoff and the input meanwhile. Reset: asynchronous,
// active low; restores initial vector, zero bit count, idle.
// ----------------------------------------------------------------------------
// md4_stream_hasher_top
// MD4 message hasher, one byte per beat in, one 128-bit digest per message out.
// ----------------------------------------------------------------------------
module md4_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_low_o,
  output logic [63:0] digest_high_o
);

  md4_pkg::md4_cmd_t cmd;
  md4_pkg::md4_sts_t sts;

  md4_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .byte_valid_i,
    .end_of_message_i,
    .out_valid_o,
    .out_ready_i,
    .sts_i            (sts),
    .cmd_o            (cmd)
  );

  md4_dpath u_dpath (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .sts_o         (sts),
    .digest_low_o,
    .digest_high_o
  );

endmodule

// ===== dv/tb_md4_stream_hasher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_md4_stream_hasher_top
// Streams directed and random-length, random-content messages byte by byte into
// the MD4 hasher, predicts each digest with a behavioral MD4 and checks every beat out.
// ----------------------------------------------------------------------------
module tb_md4_stream_hasher_top;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } byte_beat_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } digest_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        byte_valid_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] digest_low_o;
  logic [63:0] digest_high_o;

  md4_stream_hasher_top u_top (.*);

  byte_beat_t  beat_q[$];
  digest_t     digest_q[$];
  logic [31:0] chain[4];
  logic [31:0] msg_words[16];
  logic [63:0] msg_bits;
  int          mismatches;
  int          digests_seen;
  int          beats_sent;
  int          cycle_cnt;
  bit          hold_send;
  bit          in_taken;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    rotl = (x << s) | (x >> (32 - s));
  endfunction

  task automatic md4_compress();
    logic [31:0] w[4];
    logic [31:0] b, c, d, f;
    int rnd, k, wi, sh;
    int rot1[4] = '{3, 7, 11, 19};
    int rot2[4] = '{3, 5, 9, 13};
    int rot3[4] = '{3, 9, 11, 15};
    int ord3[16] = '{0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};
    for (int i = 0; i < 4; i++) w[i] = chain[i];
    for (int j = 0; j < 48; j++) begin
      rnd = j / 16;
      k = j % 16;
      b = w[(1 - j) & 3];
      c = w[(2 - j) & 3];
      d = w[(3 - j) & 3];
      if (rnd == 0) begin
        f = (b & c) | (~b & d);
        wi = k;
        sh = rot1[k % 4];
      end else if (rnd == 1) begin
        f = ((b & c) | (b & d) | (c & d)) + 32'h5A827999;
        wi = ((k & 3) << 2) | (k >> 2);
        sh = rot2[k % 4];
      end else begin
        f = (b ^ c ^ d) + 32'h6ED9EBA1;
        wi = ord3[k];
        sh = rot3[k % 4];
      end
      w[(0 - j) & 3] = rotl(w[(0 - j) & 3] + f + msg_words[wi], sh);
    end
    for (int i = 0; i < 4; i++) chain[i] += w[i];
  endtask

  task automatic put_msg_byte(input int pos, input logic [7:0] v);
    msg_words[pos / 4][(pos % 4) * 8 +: 8] = v;
    if (pos == 63) md4_compress();
  endtask

  task automatic md4_reset_state();
    chain[0] = 32'h67452301;
    chain[1] = 32'hEFCDAB89;
    chain[2] = 32'h98BADCFE;
    chain[3] = 32'h10325476;
    msg_bits = '0;
  endtask

  task automatic md4_absorb(input byte_beat_t bt);
    int pos;
    logic [63:0] total;
    digest_t dg;
    if (bt.has_byte) begin
      pos = msg_bits[8:3];
      msg_bits += 64'd8;
      put_msg_byte(pos, bt.data);
    end
    if (!bt.last) return;
    total = msg_bits;
    pos = msg_bits[8:3];
    put_msg_byte(pos, 8'h80);
    pos = (pos + 1) % 64;
    while (pos != 56) begin
      put_msg_byte(pos, 8'h00);
      pos = (pos + 1) % 64;
    end
    msg_words[14] = total[31:0];
    msg_words[15] = total[63:32];
    md4_compress();
    dg.lo = {chain[1], chain[0]};
    dg.hi = {chain[3], chain[2]};
    digest_q.push_back(dg);
    md4_reset_state();
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_msg(input int len, input bit empty_end, input bit fixed,
                           input logic [7:0] fill);
    byte_beat_t bt;
    for (int i = 0; i < len; i++) begin
      bt.data = fixed ? fill : 8'($urandom);
      bt.has_byte = 1'b1;
      bt.last = (i == len - 1) && !empty_end;
      beat_q.push_back(bt);
      // sprinkle ignored beats
      if ($urandom_range(0, 40) == 0) beat_q.push_back('{8'($urandom), 1'b0, 1'b0});
    end
    if (empty_end || len == 0) beat_q.push_back('{8'($urandom), 1'b0, 1'b1});
  endtask

  // driver
  int send_gap;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else if (in_valid_i && !in_taken) begin
      // hold
    end else begin
      if (in_taken) beats_sent <= beats_sent + 1;
      if (send_gap > 0 || beat_q.size() == 0 || hold_send) begin
        in_valid_i <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        {data_byte_i, byte_valid_i, end_of_message_i} <= beat_q.pop_front();
        in_valid_i <= 1'b1;
        send_gap <= gap_len();
      end
    end
  end

  // predictor fed from accepted beats
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken)
      md4_absorb('{data_byte_i, byte_valid_i, end_of_message_i});
  end

  // monitor
  always @(posedge clk_i) begin
    digest_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest %h %h", digest_high_o, digest_low_o);
      end else begin
        want = digest_q.pop_front();
        if (digest_low_o !== want.lo || digest_high_o !== want.hi) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: exp %h_%h got %h_%h",
                     want.hi, want.lo, digest_high_o, digest_low_o);
        end
      end
    end
  end

  int stall_len;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_len <= 0;
    end else if (stall_len > 0) begin
      out_ready_i <= 1'b0;
      stall_len <= stall_len - 1;
    end else begin
      out_ready_i <= 1'b1;
      stall_len <= gap_len();
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 2000000) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int lens[] = '{0, 1, 3, 55, 56, 57, 63, 64, 65};
    int quota;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    byte_valid_i = 1'b0;
    end_of_message_i = 1'b0;
    out_ready_i = 1'b0;
    mismatches = 0;
    digests_seen = 0;
    beats_sent = 0;
    cycle_cnt = 0;
    hold_send = 1'b0;
    in_taken = 1'b0;
    md4_reset_state();
    foreach (msg_words[i]) msg_words[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty message, short ones, all-ones/all-zero bytes
    queue_msg(0, 1'b1, 1'b0, 8'h00);
    queue_msg(1, 1'b0, 1'b1, 8'hFF);
    queue_msg(2, 1'b0, 1'b1, 8'h00);
    queue_msg(3, 1'b1, 1'b0, 8'h00);
    beat_q.push_back('{8'hA5, 1'b0, 1'b0});
    queue_msg(4, 1'b0, 1'b0, 8'h00);
    wait (beat_q.size() == 0);
    // let everything drain before going on
    hold_send = 1'b1;
    wait (digest_q.size() == 0 && !in_valid_i);
    hold_send = 1'b0;

    // random messages around block boundaries and a few multi-block ones
    quota = 1150;
    while (quota > 0) begin
      int len;
      case ($urandom_range(0, 9))
        0, 1:    len = lens[$urandom_range(0, lens.size() - 1)];
        2:       len = $urandom_range(100, 200);
        default: len = $urandom_range(0, 40);
      endcase
      queue_msg(len, len == 0 || $urandom_range(0, 3) == 0, 1'b0, 8'h00);
      quota -= len + 1;
      wait (beat_q.size() < 64);
    end
    wait (beat_q.size() == 0);
    @(negedge clk_i);
    wait (!in_valid_i && digest_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("sent %0d beats over %0d cycles, checked %0d digests",
             beats_sent, cycle_cnt, digests_seen);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== md4_stream_hasher_top.f =====
+incdir+hw/rtl
hw/rtl/md4_pkg.sv
hw/rtl/md4_ctrl.sv
hw/rtl/md4_dpath.sv
hw/rtl/md4_stream_hasher_top.sv
dv/tb_md4_stream_hasher_top.sv
